// File: sv/hfr_pkg.sv
// Shared types and constants for the host frame receiver.
// No dependencies.
`default_nettype none
package hfr_pkg;

  localparam logic [3:0] PH_PRE     = 4'd0;
  localparam logic [3:0] PH_SC1     = 4'd1;
  localparam logic [3:0] PH_SC2     = 4'd2;
  localparam logic [3:0] PH_LENH    = 4'd3;
  localparam logic [3:0] PH_LENL    = 4'd4;
  localparam logic [3:0] PH_LCS     = 4'd5;
  localparam logic [3:0] PH_ACKPOST = 4'd6;
  localparam logic [3:0] PH_DATA    = 4'd7;
  localparam logic [3:0] PH_DCS     = 4'd8;
  localparam logic [3:0] PH_POST    = 4'd9;

  localparam logic [2:0] V_OK       = 3'd0;
  localparam logic [2:0] V_ACK      = 3'd1;
  localparam logic [2:0] V_LCS_BAD  = 3'd2;
  localparam logic [2:0] V_DCS_BAD  = 3'd3;
  localparam logic [2:0] V_TOO_LONG = 3'd4;

  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic [7:0]  BYTE_FF     = 8'hFF;
  localparam logic [15:0] MAX_LEN_RST = 16'd256;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_frame;
    logic [2:0]  verdict;
    logic [15:0] frame_length;
  } hfr_res_t;

  typedef struct packed {
    logic     valid;
    hfr_res_t res;
  } hfr_beat_t;

endpackage
`default_nettype wire

// File: sv/hfr_parse.sv
// Frame parser: phase machine, length and checksum tracking, per-beat result.
// Depends on hfr_pkg.
`default_nettype none
module hfr_parse import hfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] max_len,
  output hfr_beat_t        beat
);

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [7:0]  lcs_chk;
  logic [7:0]  dcs_chk;

  assign lcs_chk = rx_byte + len_r[15:8] + len_r[7:0];
  assign dcs_chk = rx_byte + sum_r;

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    pend_nxt   = pend_r;
    beat       = '0;
    unique case (phase_r)
      PH_SC1: begin
        phase_nxt = (rx_byte == BYTE_ZERO) ? PH_SC2 : PH_PRE;
      end
      PH_SC2: begin
        if (rx_byte == BYTE_FF) begin
          phase_nxt = PH_LENH;
        end else if (rx_byte != BYTE_ZERO) begin
          phase_nxt = PH_PRE;
        end
      end
      PH_LENH: begin
        len_nxt   = {rx_byte, BYTE_ZERO};
        phase_nxt = PH_LENL;
      end
      PH_LENL: begin
        len_nxt   = {len_r[15:8], rx_byte};
        phase_nxt = PH_LCS;
      end
      PH_LCS: begin
        if (len_r == 16'd0 && rx_byte == BYTE_FF) begin
          phase_nxt = PH_ACKPOST;
        end else if (lcs_chk != BYTE_ZERO) begin
          beat.valid            = 1'b1;
          beat.res.end_of_frame = 1'b1;
          beat.res.verdict      = V_LCS_BAD;
          beat.res.frame_length = len_r;
          phase_nxt             = PH_PRE;
        end else if (len_r > max_len) begin
          beat.valid            = 1'b1;
          beat.res.end_of_frame = 1'b1;
          beat.res.verdict      = V_TOO_LONG;
          beat.res.frame_length = len_r;
          phase_nxt             = PH_PRE;
        end else begin
          sum_nxt    = BYTE_ZERO;
          remain_nxt = len_r;
          phase_nxt  = (len_r == 16'd0) ? PH_DCS : PH_DATA;
        end
      end
      PH_ACKPOST: begin
        beat.valid            = 1'b1;
        beat.res.end_of_frame = 1'b1;
        beat.res.verdict      = V_ACK;
        phase_nxt             = PH_PRE;
      end
      PH_DATA: begin
        sum_nxt            = sum_r + rx_byte;
        remain_nxt         = remain_r - 16'd1;
        beat.valid         = 1'b1;
        beat.res.data_byte = rx_byte;
        if (remain_r == 16'd1) begin
          phase_nxt = PH_DCS;
        end
      end
      PH_DCS: begin
        pend_nxt  = (dcs_chk == BYTE_ZERO) ? V_OK : V_DCS_BAD;
        phase_nxt = PH_POST;
      end
      PH_POST: begin
        beat.valid            = 1'b1;
        beat.res.end_of_frame = 1'b1;
        beat.res.verdict      = pend_r;
        beat.res.frame_length = len_r;
        phase_nxt             = PH_PRE;
      end
      default: begin
        phase_nxt = (rx_byte == BYTE_ZERO) ? PH_SC1 : PH_PRE;
      end
    endcase
    if (!accept) begin
      beat.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PRE;
      len_r    <= '0;
      remain_r <= '0;
      sum_r    <= '0;
      pend_r   <= V_OK;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/hfr_out_buf.sv
// Result register with one skid entry between parser and output channel.
// Depends on hfr_pkg.
`default_nettype none
module hfr_out_buf import hfr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hfr_beat_t push,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output hfr_res_t       out_res
);

  logic     main_v_r, main_v_nxt;
  logic     skid_v_r, skid_v_nxt;
  hfr_res_t main_d_r, skid_d_r;
  logic     pop;
  logic     load_main_push, load_main_skid, load_skid;

  assign pop       = main_v_r & ~out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_d_r;

  always_comb begin
    main_v_nxt     = main_v_r;
    skid_v_nxt     = skid_v_r;
    load_main_push = 1'b0;
    load_main_skid = 1'b0;
    load_skid      = 1'b0;
    if (skid_v_r) begin
      if (pop) begin
        load_main_skid = 1'b1;
        skid_v_nxt     = 1'b0;
      end
    end else if (!main_v_r || pop) begin
      main_v_nxt     = push.valid;
      load_main_push = push.valid;
    end else if (push.valid) begin
      skid_v_nxt = 1'b1;
      load_skid  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main_push) begin
      main_d_r <= push.res;
    end else if (load_main_skid) begin
      main_d_r <= skid_d_r;
    end
    if (load_skid) begin
      skid_d_r <= push.res;
    end
  end

endmodule
`default_nettype wire

// File: sv/host_frame_receiver.sv
// Host frame receiver top level: deframes received bytes, at most one beat per cycle.
// Each result is registered in the output buffer before it reaches the output.
// Throughput: one byte per cycle; input stalls only when the skid entry is full.
// Reset (synchronous, rst_n low): preamble hunt, counters and sums cleared,
// output empty, max_len_r back to 256.
// Depends on hfr_pkg, hfr_parse, hfr_out_buf.
`default_nettype none
module host_frame_receiver import hfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_data_byte,
  output logic             out_end_of_frame,
  output logic [2:0]       out_verdict,
  output logic [15:0]      out_frame_length,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic [15:0] max_len_r;
  logic        buf_full;
  logic        accept;
  hfr_beat_t   beat;
  hfr_res_t    res;

  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  hfr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .max_len (max_len_r),
    .beat    (beat)
  );

  hfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (beat),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_data_byte    = res.data_byte;
  assign out_end_of_frame = res.end_of_frame;
  assign out_verdict      = res.verdict;
  assign out_frame_length = res.frame_length;

endmodule
`default_nettype wire
